[rtl/core/logistic_regression_sgd_trainer_macros.svh]
//------------------------------------------------------------------------------
// Assertion macros for the logistic regression trainer
// Shorthand for clocked checks on i_clk, gated off while i_rst_n is low.
//------------------------------------------------------------------------------
`ifndef LOGISTIC_REGRESSION_SGD_TRAINER_MACROS_SVH
`define LOGISTIC_REGRESSION_SGD_TRAINER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define LRST_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LRST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/lrst_pkg.sv]
//------------------------------------------------------------------------------
// lrst_pkg
// Shared widths, sample word layout and the sigmoid lookup table.
//------------------------------------------------------------------------------
`default_nettype none

package lrst_pkg;

    localparam int FEAT_W      = 16;
    localparam int WEIGHT_W    = 32;
    localparam int PROB_W      = 16;
    localparam int SAMPLE_W    = 3 * FEAT_W + 1;
    localparam int SIG_ENTRIES = 256;
    localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Weighted sum offset (8.0 with 31 fraction bits) and top of the table range
    localparam int Z_OFF_BIT = 34;
    localparam int Z_TOP_BIT = 35;

    typedef logic [PROB_W-1:0] t_sig_tab [SIG_ENTRIES];

    // Shift-subtract quotient, used only while building the table
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sigmoid at the center of each table interval, fixed point exp/divide
    function automatic t_sig_tab build_sig_tab();
        t_sig_tab            tab;
        longint              num;
        logic [63:0]         mag;
        logic [63:0]         aq;
        logic [63:0]         m;
        logic [63:0]         f;
        logic [63:0]         em;
        logic [63:0]         term;
        longint              sum;
        logic [63:0]         e;
        logic [63:0]         p;
        for (int k = 0; k < SIG_ENTRIES; k++) begin
            num  = 64'(16 * k + 8) - 64'(8 * SIG_ENTRIES);
            mag  = (num < 0) ? 64'(-num) : 64'(num);
            aq   = (mag << 32) >> SIG_IDX_W;
            m    = aq >> 32;
            f    = aq & 64'hFFFF_FFFF;
            em   = 64'h1_0000_0000;
            term = 64'h1_0000_0000;
            sum  = 64'h1_0000_0000;
            for (longint j = 0; j < longint'(m); j++) begin
                em = (em * 64'd1580030169) >> 32;
            end
            for (int n = 1; n <= 13; n++) begin
                term = udiv64((term * f) >> 32, 64'(n));
                if (n[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            e = (em * 64'(sum)) >> 32;
            if (num > 0) begin
                p = udiv64(64'd1 << 48, 64'h1_0000_0000 + e);
                if (p > 64'd65535) begin
                    p = 64'd65535;
                end
            end else begin
                p = udiv64(e << 16, 64'h1_0000_0000 + e);
            end
            tab[k] = p[PROB_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TAB = build_sig_tab();

    // Configuration register indexes
    localparam logic REG_LRATE  = 1'b0;
    localparam logic REG_EPOCHS = 1'b1;

    // Input modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_TRAIN = 2'd1;
    localparam logic [1:0] MODE_SCORE = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

endpackage

`default_nettype wire

[rtl/core/lrst_ram.sv]
//------------------------------------------------------------------------------
// lrst_ram
// Single port synchronous RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module lrst_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/lrst_mul.sv]
//------------------------------------------------------------------------------
// lrst_mul
// Shared signed multiplier with a registered product.
//------------------------------------------------------------------------------
`default_nettype none

module lrst_mul (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [lrst_pkg::MUL_A_W-1:0]  i_a,
    input  wire logic signed [lrst_pkg::MUL_B_W-1:0]  i_b,
    output logic signed      [lrst_pkg::MUL_P_W-1:0]  o_p
);
    import lrst_pkg::*;

    // Register the product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
        end
    end

endmodule

`default_nettype wire

[rtl/core/logistic_regression_sgd_trainer.sv]
// Load and clear items finish in idle; a score item runs products, lookup and done states.
// A training item runs epoch_count passes over the stored samples; each sample steps
// through the single shared multiplier (read, 3 products, lookup, error, 4 updates).
// The next item is taken once the sequencer is back in idle, even while a result waits.
// Reset (i_rst_n low, synchronous) empties the store, zeroes the weights and restores
// step rate = 655, epoch_count = 1000. The sample RAM needs no clearing pass.
//------------------------------------------------------------------------------
// logistic_regression_sgd_trainer
// Logistic regression scorer and SGD trainer over a RAM of labelled samples.
//------------------------------------------------------------------------------
`default_nettype none

module logistic_regression_sgd_trainer #(
    parameter int MAX_SAMPLES = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input items
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // tdata: position_feature, length_feature, keyword_feature, label, zero pad
    input  wire logic [55:0] i_s_tdata,
    // tuser: mode
    input  wire logic [1:0]  i_s_tuser,
    // Result items
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // tdata: probability, weight_position, weight_length, weight_keywords,
    //        samples_used, zero pad
    output logic [127:0]     o_m_tdata,
    // tuser: result_kind
    output logic [0:0]       o_m_tuser,
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import lrst_pkg::*;

    `include "logistic_regression_sgd_trainer_macros.svh"

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_MAC  = 7'b0000100,
        S_SUM  = 7'b0001000,
        S_ERR  = 7'b0010000,
        S_UPD  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state                      r_state;
    logic [1:0]                  r_cnt;
    logic                        r_train;
    logic [CW-1:0]               r_sidx;
    logic [15:0]                 r_epoch;
    logic [CW-1:0]               r_count;
    logic [15:0]                 r_lrate;
    logic [15:0]                 r_epochs;
    logic [FEAT_W-1:0]           r_x [3];
    logic signed [WEIGHT_W-1:0]  r_w [3];
    logic signed [MUL_P_W-1:0]   r_acc;
    logic [PROB_W-1:0]           r_p;
    logic signed [MUL_A_W-1:0]   r_re;
    logic                        r_ovalid;
    logic                        r_okind;
    logic [PROB_W-1:0]           r_oprob;
    logic [WEIGHT_W-1:0]         r_ow [3];
    logic [9:0]                  r_osamp;

    logic                        in_acc;
    logic                        cfg_wr;
    logic                        ram_we;
    logic                        ram_re;
    logic [AW-1:0]               ram_addr;
    logic [SAMPLE_W-1:0]         ram_wdata;
    logic [SAMPLE_W-1:0]         ram_rdata;
    logic                        mul_en;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_P_W-1:0]   mul_p;
    logic [FEAT_W-1:0]           x_cur;
    logic signed [WEIGHT_W-1:0]  w_cur;
    logic                        s_label;
    logic signed [MUL_P_W-1:0]   z_sum;
    logic signed [MUL_P_W-1:0]   z_off;
    logic [SIG_IDX_W-1:0]        sig_idx;
    logic signed [MUL_B_W-1:0]   err;
    logic [MUL_P_W-1:0]          v_mag;
    logic [MUL_P_W-32:0]         d_mag;
    logic signed [WEIGHT_W+1:0]  w_sum;
    logic signed [WEIGHT_W-1:0]  w_sat;
    logic [31:0]                 samp_ext;
    logic                        last_sample;
    logic                        out_free;

    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign out_free   = !r_ovalid || i_m_tready;

    // Read back configuration registers
    always_comb begin
        unique case (paddr[2])
            REG_LRATE:  prdata = {16'b0, r_lrate};
            REG_EPOCHS: prdata = {16'b0, r_epochs};
            default:    prdata = 32'b0;
        endcase
    end

    // Sample RAM access: writes on load, reads one sample per training step
    assign ram_we    = in_acc && (i_s_tuser == MODE_LOAD) && (r_count < CW'(MAX_SAMPLES));
    assign ram_re    = (r_state == S_RD);
    assign ram_addr  = (r_state == S_RD) ? r_sidx[AW-1:0] : r_count[AW-1:0];
    assign ram_wdata = i_s_tdata[SAMPLE_W-1:0];

    lrst_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Select the current feature and weight by step counter
    always_comb begin
        case (r_cnt)
            2'd0: begin
                x_cur = r_train ? ram_rdata[FEAT_W-1:0] : r_x[0];
                w_cur = r_w[0];
            end
            2'd1: begin
                x_cur = r_train ? ram_rdata[2*FEAT_W-1:FEAT_W] : r_x[1];
                w_cur = r_w[1];
            end
            2'd2: begin
                x_cur = r_train ? ram_rdata[3*FEAT_W-1:2*FEAT_W] : r_x[2];
                w_cur = r_w[2];
            end
            default: begin
                x_cur = '0;
                w_cur = '0;
            end
        endcase
    end
    assign s_label = ram_rdata[SAMPLE_W-1];

    // Weighted sum to table index, clamped at both ends
    assign z_sum = r_acc + mul_p;
    assign z_off = z_sum + (MUL_P_W'(1) <<< Z_OFF_BIT);
    always_comb begin
        if (z_off < 0) begin
            sig_idx = '0;
        end else if (z_off >= (MUL_P_W'(1) <<< Z_TOP_BIT)) begin
            sig_idx = '1;
        end else begin
            sig_idx = z_off[Z_TOP_BIT-1 -: SIG_IDX_W];
        end
    end

    assign err = $signed({1'b0, s_label, 16'b0}) - $signed({2'b0, r_p});

    // Multiplier operands per step
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            S_MAC: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(w_cur);
                mul_b  = $signed({2'b0, x_cur});
            end
            S_ERR: begin
                mul_en = 1'b1;
                mul_a  = $signed({{(MUL_A_W-16){1'b0}}, r_lrate});
                mul_b  = err;
            end
            S_UPD: begin
                mul_en = (r_cnt != 2'd3);
                mul_a  = (r_cnt == 2'd0) ? mul_p[MUL_A_W-1:0] : r_re;
                mul_b  = $signed({2'b0, x_cur});
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    lrst_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Round the update half away from zero and add with saturation
    always_comb begin
        v_mag = mul_p[MUL_P_W-1] ? MUL_P_W'(-mul_p) : MUL_P_W'(mul_p);
        d_mag = (MUL_P_W-31)'((v_mag + (MUL_P_W'(1) << 30)) >> 31);
        case (r_cnt)
            2'd1:    w_sum = (WEIGHT_W+2)'(r_w[0]);
            2'd2:    w_sum = (WEIGHT_W+2)'(r_w[1]);
            default: w_sum = (WEIGHT_W+2)'(r_w[2]);
        endcase
        if (mul_p[MUL_P_W-1]) begin
            w_sum = w_sum - $signed((WEIGHT_W+2)'(d_mag));
        end else begin
            w_sum = w_sum + $signed((WEIGHT_W+2)'(d_mag));
        end
        if (w_sum > (WEIGHT_W+2)'(32'sh7FFF_FFFF)) begin
            w_sat = 32'sh7FFF_FFFF;
        end else if (w_sum < -(WEIGHT_W+2)'(33'sh0_8000_0000)) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = w_sum[WEIGHT_W-1:0];
        end
    end

    assign last_sample = ((r_sidx + CW'(1)) == r_count);
    assign samp_ext    = 32'(r_count);

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_train  <= 1'b0;
            r_sidx   <= '0;
            r_epoch  <= '0;
            r_count  <= '0;
            r_lrate  <= 16'd655;
            r_epochs <= 16'd1000;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_w[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_LRATE:  r_lrate  <= pwdata[15:0];
                    REG_EPOCHS: r_epochs <= pwdata[15:0];
                    default:    r_lrate  <= r_lrate;
                endcase
            end
            // Post a finished result, drop it once taken
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_s_tuser)
                            MODE_LOAD: begin
                                if (ram_we) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            MODE_TRAIN: begin
                                r_train <= 1'b1;
                                r_sidx  <= '0;
                                r_epoch <= '0;
                                for (int i = 0; i < 3; i++) begin
                                    r_w[i] <= '0;
                                end
                                if (r_count == '0 || r_epochs == 16'd0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            MODE_SCORE: begin
                                r_train <= 1'b0;
                                r_cnt   <= '0;
                                r_state <= S_MAC;
                            end
                            MODE_CLEAR: begin
                                r_count <= '0;
                            end
                            default: begin
                                r_count <= r_count;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_cnt   <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd2) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_state <= r_train ? S_ERR : S_DONE;
                end
                S_ERR: begin
                    r_cnt   <= '0;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_cnt <= r_cnt + 2'd1;
                    case (r_cnt)
                        2'd1: r_w[0] <= w_sat;
                        2'd2: r_w[1] <= w_sat;
                        2'd3: r_w[2] <= w_sat;
                        default: r_w[0] <= r_w[0];
                    endcase
                    if (r_cnt == 2'd3) begin
                        if (last_sample) begin
                            r_sidx <= '0;
                            if ((r_epoch + 16'd1) == r_epochs) begin
                                r_state <= S_DONE;
                            end else begin
                                r_epoch <= r_epoch + 16'd1;
                                r_state <= S_RD;
                            end
                        end else begin
                            r_sidx  <= r_sidx + CW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers: score inputs, accumulator, probability, result
    always_ff @(posedge i_clk) begin
        if (in_acc && i_s_tuser == MODE_SCORE) begin
            r_x[0] <= i_s_tdata[FEAT_W-1:0];
            r_x[1] <= i_s_tdata[2*FEAT_W-1:FEAT_W];
            r_x[2] <= i_s_tdata[3*FEAT_W-1:2*FEAT_W];
        end
        if (r_state == S_MAC) begin
            r_acc <= (r_cnt == 2'd0) ? '0 : z_sum;
        end
        if (r_state == S_SUM) begin
            r_p <= SIG_TAB[sig_idx];
        end
        if (r_state == S_UPD && r_cnt == 2'd0) begin
            r_re <= mul_p[MUL_A_W-1:0];
        end
        if (r_state == S_DONE && out_free) begin
            r_okind <= r_train;
            r_oprob <= r_train ? '0 : r_p;
            r_ow[0] <= r_w[0];
            r_ow[1] <= r_w[1];
            r_ow[2] <= r_w[2];
            r_osamp <= samp_ext[9:0];
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_okind;
    assign o_m_tdata  = {6'b0, r_osamp, r_ow[2], r_ow[1], r_ow[0], r_oprob};

    // Checks
    `LRST_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CW'(MAX_SAMPLES), "sample count overflow")
    `LRST_ASSERT_IMPL(a_we_idle, ram_we, r_state == S_IDLE, "store written while busy")
    `LRST_ASSERT_NEXT(a_done_out, r_state == S_DONE && out_free, r_ovalid, "result not posted")
    `LRST_ASSERT_IMPL(a_rd_range, r_state == S_RD, r_sidx < r_count, "read beyond stored samples")

endmodule

`default_nettype wire
